// File: hw/rtl/clt_pkg.sv
// Shared types, character codes and sizes for the command line tokenizer.
package clt_pkg;

    localparam int MAX_TEXT_LEN = 65536;
    localparam int POS_W        = (MAX_TEXT_LEN > 2) ? $clog2(MAX_TEXT_LEN) : 1;
    localparam int OFFSET_W     = 16;
    localparam int MAX_RESULTS  = 3;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [9:0] {
        M_IDLE         = 10'b00_0000_0001,
        M_IDLE_SLASH   = 10'b00_0000_0010,
        M_COMMENT      = 10'b00_0000_0100,
        M_COMMENT_STAR = 10'b00_0000_1000,
        M_SKIP         = 10'b00_0001_0000,
        M_QUOTE        = 10'b00_0010_0000,
        M_QUOTE_ESC    = 10'b00_0100_0000,
        M_WORD         = 10'b00_1000_0000,
        M_WORD_ESC     = 10'b01_0000_0000,
        M_WORD_SLASH   = 10'b10_0000_0000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          token_byte;
        logic [OFFSET_W-1:0] resume_offset;
        logic                last_of_run;
    } token_item_t;

endpackage

// File: hw/rtl/command_line_tokenizer.sv
// Top level of the streaming command line tokenizer with its result queue.
//
//   Channel   Signals                             Direction  Payload
//   text      text_valid, text_ready, text_data   input      clt_pkg::text_item_t
//   token     tok_valid, tok_ready, tok_data      output     clt_pkg::token_item_t
//
// A text byte is lexed in the cycle it is accepted and its zero to three results are
// written into a four-entry result queue; the queue delivers one result per cycle while tok_ready is high.
// A new byte is taken in every cycle while the queue holds at most one result, so a
// byte that yields two or three results can stall the input until the queue drains.
// Reset puts the lexer between tokens at offset zero and empties the queue.
// A stalled output only fills the queue; the lexer state waits with the input.
module command_line_tokenizer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  clt_pkg::text_item_t   text_data,
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output clt_pkg::token_item_t  tok_data
);

    clt_pkg::lex_mode_t                mode_reg, mode_next;
    logic [clt_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [clt_pkg::POS_W-1:0]         resume_reg, resume_next;

    clt_pkg::token_item_t              fifo_reg [clt_pkg::FIFO_DEPTH];
    logic [clt_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [clt_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [clt_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;

    clt_pkg::token_item_t              res [clt_pkg::MAX_RESULTS];
    logic [clt_pkg::RES_CNT_W-1:0]     res_cnt;

    logic                              accept;
    logic                              pop;

    function automatic logic [clt_pkg::OFFSET_W-1:0] to_offset(
        input logic [clt_pkg::POS_W-1:0] pos
    );
        logic [clt_pkg::POS_W+clt_pkg::OFFSET_W-1:0] wide;
        wide = {{clt_pkg::OFFSET_W{1'b0}}, pos};
        return wide[clt_pkg::OFFSET_W-1:0];
    endfunction

    assign text_ready = (count_reg <= clt_pkg::FIFO_CNT_W'(clt_pkg::FIFO_DEPTH
                                                          - clt_pkg::MAX_RESULTS));
    assign accept     = text_valid && text_ready;
    assign tok_valid  = (count_reg != '0);
    assign pop        = tok_valid && tok_ready;
    assign tok_data   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        logic [7:0]                c;
        logic                      last;
        logic                      do_word;
        logic [clt_pkg::POS_W-1:0] p;
        logic [clt_pkg::POS_W-1:0] end_resume;
        logic                      do_end;
        logic [clt_pkg::RES_CNT_W-1:0] n;
        logic                      slash_first;

        c           = text_data.text_byte;
        p           = pos_reg;
        last        = text_data.end_of_text
                      || (p >= clt_pkg::POS_W'(clt_pkg::MAX_TEXT_LEN - 1));
        do_word     = 1'b0;
        do_end      = 1'b0;
        slash_first = 1'b0;
        end_resume  = p + 1'b1;
        mode_next   = mode_reg;
        n           = '0;
        for (int i = 0; i < clt_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        unique case (mode_reg)
            clt_pkg::M_IDLE:
            begin
                priority if (c <= clt_pkg::CH_SPACE)
                begin
                end
                else if (c == clt_pkg::CH_SLASH && !last)
                begin
                    mode_next = clt_pkg::M_IDLE_SLASH;
                end
                else if (c == clt_pkg::CH_QUOTE && !last)
                begin
                    mode_next = clt_pkg::M_QUOTE;
                end
                else if (last)
                begin
                    if (c != clt_pkg::CH_BSLASH)
                    begin
                        res[n] = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                        n      = n + 1'b1;
                    end
                    do_end = 1'b1;
                end
                else if (c == clt_pkg::CH_BSLASH)
                begin
                    mode_next = clt_pkg::M_WORD_ESC;
                end
                else
                begin
                    res[n]    = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                    n         = n + 1'b1;
                    mode_next = clt_pkg::M_WORD;
                end
            end
            clt_pkg::M_IDLE_SLASH:
            begin
                priority if (c == clt_pkg::CH_SLASH)
                begin
                    mode_next = clt_pkg::M_SKIP;
                end
                else if (c == clt_pkg::CH_STAR)
                begin
                    mode_next = clt_pkg::M_COMMENT;
                end
                else
                begin
                    slash_first = 1'b1;
                end
            end
            clt_pkg::M_COMMENT:
            begin
                if (c == clt_pkg::CH_STAR)
                begin
                    mode_next = clt_pkg::M_COMMENT_STAR;
                end
            end
            clt_pkg::M_COMMENT_STAR:
            begin
                priority if (c == clt_pkg::CH_SLASH)
                begin
                    mode_next = clt_pkg::M_IDLE;
                end
                else if (c != clt_pkg::CH_STAR)
                begin
                    mode_next = clt_pkg::M_COMMENT;
                end
                else
                begin
                end
            end
            clt_pkg::M_SKIP:
            begin
            end
            clt_pkg::M_QUOTE:
            begin
                priority if (last)
                begin
                    if (c != clt_pkg::CH_QUOTE)
                    begin
                        res[n] = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                        n      = n + 1'b1;
                    end
                    do_end = 1'b1;
                end
                else if (c == clt_pkg::CH_QUOTE)
                begin
                    do_end    = 1'b1;
                    mode_next = clt_pkg::M_IDLE;
                end
                else if (c == clt_pkg::CH_BSLASH)
                begin
                    mode_next = clt_pkg::M_QUOTE_ESC;
                end
                else
                begin
                    res[n] = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                    n      = n + 1'b1;
                end
            end
            clt_pkg::M_QUOTE_ESC:
            begin
                res[n] = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                n      = n + 1'b1;
                if (last)
                begin
                    do_end = 1'b1;
                end
                else
                begin
                    mode_next = clt_pkg::M_QUOTE;
                end
            end
            clt_pkg::M_WORD:
            begin
                do_word = 1'b1;
            end
            clt_pkg::M_WORD_ESC:
            begin
                if (last)
                begin
                    do_end = 1'b1;
                end
                else
                begin
                    res[n]    = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                    n         = n + 1'b1;
                    mode_next = clt_pkg::M_WORD;
                end
            end
            clt_pkg::M_WORD_SLASH:
            begin
                if (c == clt_pkg::CH_SLASH || c == clt_pkg::CH_STAR)
                begin
                    do_end     = 1'b1;
                    end_resume = p - 1'b1;
                    mode_next  = (c == clt_pkg::CH_SLASH) ? clt_pkg::M_SKIP
                                                          : clt_pkg::M_COMMENT;
                end
                else
                begin
                    slash_first = 1'b1;
                end
            end
            default:
            begin
                mode_next = clt_pkg::M_IDLE;
            end
        endcase

        // A held slash that turned out not to open a comment is a token byte.
        if (slash_first)
        begin
            res[n]  = '{clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH, '0, 1'b0};
            n       = n + 1'b1;
            do_word = 1'b1;
        end

        if (do_word)
        begin
            priority if (last)
            begin
                if (c > clt_pkg::CH_SPACE)
                begin
                    res[n] = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                    n      = n + 1'b1;
                end
                do_end = 1'b1;
            end
            else if (c <= clt_pkg::CH_SPACE)
            begin
                do_end    = 1'b1;
                mode_next = clt_pkg::M_IDLE;
            end
            else if (c == clt_pkg::CH_QUOTE)
            begin
                do_end     = 1'b1;
                end_resume = p;
                mode_next  = clt_pkg::M_QUOTE;
            end
            else if (c == clt_pkg::CH_SLASH)
            begin
                mode_next = clt_pkg::M_WORD_SLASH;
            end
            else if (c == clt_pkg::CH_BSLASH)
            begin
                mode_next = clt_pkg::M_WORD_ESC;
            end
            else
            begin
                res[n]    = '{clt_pkg::KIND_BYTE, c, '0, 1'b0};
                n         = n + 1'b1;
                mode_next = clt_pkg::M_WORD;
            end
        end

        resume_next = resume_reg;
        if (do_end)
        begin
            res[n]      = '{clt_pkg::KIND_END, 8'h00, to_offset(resume_reg), 1'b0};
            n           = n + 1'b1;
            resume_next = end_resume;
        end

        if (n != '0)
        begin
            res[n - 1'b1].last_of_run = 1'b1;
        end
        res_cnt = n;

        if (last)
        begin
            mode_next   = clt_pkg::M_IDLE;
            pos_next    = '0;
            resume_next = '0;
        end
        else
        begin
            pos_next = p + 1'b1;
        end
    end

    always_comb
    begin
        logic [clt_pkg::RES_CNT_W-1:0] pushed;
        pushed      = accept ? res_cnt : '0;
        wr_ptr_next = wr_ptr_reg + clt_pkg::FIFO_PTR_W'(pushed);
        rd_ptr_next = rd_ptr_reg + clt_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + clt_pkg::FIFO_CNT_W'(pushed)
                      - clt_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= clt_pkg::M_IDLE;
            pos_reg    <= '0;
            resume_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                resume_reg <= resume_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < clt_pkg::MAX_RESULTS; i++)
        begin
            if (accept && (clt_pkg::RES_CNT_W'(i) < res_cnt))
            begin
                fifo_reg[wr_ptr_reg + clt_pkg::FIFO_PTR_W'(i)] <= res[i];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clt_pkg::FIFO_CNT_W'(clt_pkg::FIFO_DEPTH))
        else $error("Result queue holds more transactions than its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_data.end_of_text
        |=> pos_reg == '0 && resume_reg == '0 && mode_reg == clt_pkg::M_IDLE)
        else $error("Lexer state did not return to its start after the final byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        resume_reg <= pos_reg)
        else $error("Resume offset lies beyond the current byte offset.");

endmodule
